// ===== rtl/core/msqrt_pkg.sv =====
// Package for the modular square root block: data width, counter widths, candidate
// search bounds and the modular addition used by the multiplier. No dependencies.
package msqrt_pkg;

  localparam int WIDTH = 64;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int SM_W = $clog2(WIDTH + 1) + 1;
  localparam int CAND_W = 13;
  localparam logic [CAND_W-1:0] CAND_FIRST = CAND_W'(2);
  localparam logic [CAND_W-1:0] CAND_END = CAND_W'(2 + 4096);

  typedef logic [WIDTH-1:0] data_t;

  // (x + y) mod m for x, y below m, without overflow.
  function automatic data_t add_mod(data_t x, data_t y, data_t m);
    data_t gap;
    gap = m - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

endpackage

// ===== rtl/core/modular_square_root_top.sv =====
// Modular square root top level: Tonelli-Shanks sequencer, modulus register and
// output register. Depends on msqrt_pkg and msqrt_mulmod.
// Each step is a bit-serial modular product or an exponentiation; a root needs up to four
// exponentiations, one more per candidate tried, and up to s*s products. One item at a time;
// the next transfer is taken while a result waits at the output. Synchronous active-low
// reset clears control and loads modulus 3.
module modular_square_root_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_root,
  output logic        out_has_root,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  localparam int W = msqrt_pkg::WIDTH;
  localparam int SW = 5;
  localparam logic [SW-1:0] S_IDLE = 5'd0;
  localparam logic [SW-1:0] S_MULW = 5'd1;
  localparam logic [SW-1:0] S_RED = 5'd2;
  localparam logic [SW-1:0] S_PSQ = 5'd3;
  localparam logic [SW-1:0] S_PSQD = 5'd4;
  localparam logic [SW-1:0] S_PMD = 5'd5;
  localparam logic [SW-1:0] S_PADV = 5'd6;
  localparam logic [SW-1:0] S_EUL = 5'd7;
  localparam logic [SW-1:0] S_FIN3 = 5'd8;
  localparam logic [SW-1:0] S_QS = 5'd9;
  localparam logic [SW-1:0] S_NR = 5'd10;
  localparam logic [SW-1:0] S_NRC = 5'd11;
  localparam logic [SW-1:0] S_CD = 5'd12;
  localparam logic [SW-1:0] S_XD = 5'd13;
  localparam logic [SW-1:0] S_TD = 5'd14;
  localparam logic [SW-1:0] S_LOOP = 5'd15;
  localparam logic [SW-1:0] S_SQL = 5'd16;
  localparam logic [SW-1:0] S_SQD = 5'd17;
  localparam logic [SW-1:0] S_BL = 5'd18;
  localparam logic [SW-1:0] S_BD = 5'd19;
  localparam logic [SW-1:0] S_B2 = 5'd20;
  localparam logic [SW-1:0] S_XU = 5'd21;
  localparam logic [SW-1:0] S_TU = 5'd22;
  localparam logic [SW-1:0] S_FIN = 5'd23;

  localparam int SMW = msqrt_pkg::SM_W;

  logic [SW-1:0]                state_r, state_nxt;
  logic [SW-1:0]                mret_r, mret_nxt;
  logic [SW-1:0]                pret_r, pret_nxt;
  logic                         go_r, go_nxt;
  msqrt_pkg::data_t             mx_r, mx_nxt, my_r, my_nxt;
  logic [63:0]                  mod_r;
  msqrt_pkg::data_t             p_r, p_nxt, a_r, a_nxt, half_r, half_nxt;
  msqrt_pkg::data_t             q_r, q_nxt, c_r, c_nxt, x_r, x_nxt, t_r, t_nxt;
  msqrt_pkg::data_t             tt_r, tt_nxt, b_r, b_nxt;
  msqrt_pkg::data_t             pacc_r, pacc_nxt, pbase_r, pbase_nxt, pexp_r, pexp_nxt;
  logic [msqrt_pkg::CNT_W-1:0]  pbit_r, pbit_nxt;
  logic [SMW-1:0]               s_r, s_nxt, m_r, m_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [msqrt_pkg::CAND_W-1:0] cand_r, cand_nxt;
  msqrt_pkg::data_t             froot_r, froot_nxt;
  logic                         fhas_r, fhas_nxt;
  logic                         ov_r, ov_nxt;
  logic [63:0]                  oroot_r, oroot_nxt;
  logic                         ohas_r, ohas_nxt;
  logic                         mul_busy, mul_done;
  msqrt_pkg::data_t             mres;
  msqrt_pkg::data_t             vin, pin, one;
  logic                         accept;

  assign one = msqrt_pkg::data_t'(1);
  assign vin = in_value[W-1:0];
  assign pin = mod_r[W-1:0];
  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;

  msqrt_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .x     (mx_r),
    .y     (my_r),
    .p     (p_r),
    .busy  (mul_busy),
    .done  (mul_done),
    .res   (mres)
  );

  always_comb begin
    state_nxt = state_r;
    mret_nxt = mret_r;
    pret_nxt = pret_r;
    go_nxt = 1'b0;
    mx_nxt = mx_r;
    my_nxt = my_r;
    p_nxt = p_r;
    a_nxt = a_r;
    half_nxt = half_r;
    q_nxt = q_r;
    c_nxt = c_r;
    x_nxt = x_r;
    t_nxt = t_r;
    tt_nxt = tt_r;
    b_nxt = b_r;
    pacc_nxt = pacc_r;
    pbase_nxt = pbase_r;
    pexp_nxt = pexp_r;
    pbit_nxt = pbit_r;
    s_nxt = s_r;
    m_nxt = m_r;
    i_nxt = i_r;
    j_nxt = j_r;
    cand_nxt = cand_r;
    froot_nxt = froot_r;
    fhas_nxt = fhas_r;
    ov_nxt = ov_r;
    oroot_nxt = oroot_r;
    ohas_nxt = ohas_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          p_nxt = pin;
          froot_nxt = '0;
          fhas_nxt = 1'b0;
          if (pin < msqrt_pkg::data_t'(3) || !pin[0]) begin
            state_nxt = S_FIN;
          end else begin
            mx_nxt = one;
            my_nxt = vin;
            go_nxt = 1'b1;
            mret_nxt = S_RED;
            state_nxt = S_MULW;
          end
        end
      end
      S_MULW: begin
        if (mul_done) begin
          state_nxt = mret_r;
        end
      end
      S_RED: begin
        a_nxt = mres;
        half_nxt = (p_r - one) >> 1;
        if (mres == '0) begin
          fhas_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          pbase_nxt = mres;
          pexp_nxt = (p_r - one) >> 1;
          pacc_nxt = one;
          pbit_nxt = msqrt_pkg::CNT_W'(W - 1);
          pret_nxt = S_EUL;
          state_nxt = S_PSQ;
        end
      end
      S_PSQ: begin
        mx_nxt = pacc_r;
        my_nxt = pacc_r;
        go_nxt = 1'b1;
        mret_nxt = S_PSQD;
        state_nxt = S_MULW;
      end
      S_PSQD: begin
        pacc_nxt = mres;
        if (pexp_r[pbit_r]) begin
          mx_nxt = mres;
          my_nxt = pbase_r;
          go_nxt = 1'b1;
          mret_nxt = S_PMD;
          state_nxt = S_MULW;
        end else begin
          state_nxt = S_PADV;
        end
      end
      S_PMD: begin
        pacc_nxt = mres;
        state_nxt = S_PADV;
      end
      S_PADV: begin
        if (pbit_r == '0) begin
          state_nxt = pret_r;
        end else begin
          pbit_nxt = pbit_r - 1'b1;
          state_nxt = S_PSQ;
        end
      end
      S_EUL: begin
        if (pacc_r != one) begin
          state_nxt = S_FIN;
        end else if (p_r[1:0] == 2'b11) begin
          pbase_nxt = a_r;
          pexp_nxt = (p_r >> 2) + one;
          pacc_nxt = one;
          pbit_nxt = msqrt_pkg::CNT_W'(W - 1);
          pret_nxt = S_FIN3;
          state_nxt = S_PSQ;
        end else begin
          q_nxt = p_r - one;
          s_nxt = '0;
          state_nxt = S_QS;
        end
      end
      S_FIN3: begin
        froot_nxt = pacc_r;
        fhas_nxt = 1'b1;
        state_nxt = S_FIN;
      end
      S_QS: begin
        if (!q_r[0]) begin
          q_nxt = q_r >> 1;
          s_nxt = s_r + 1'b1;
        end else begin
          cand_nxt = msqrt_pkg::CAND_FIRST;
          state_nxt = S_NR;
        end
      end
      S_NR: begin
        if (64'(cand_r) < 64'(p_r) && cand_r < msqrt_pkg::CAND_END) begin
          pbase_nxt = W'(cand_r);
          pexp_nxt = half_r;
          pacc_nxt = one;
          pbit_nxt = msqrt_pkg::CNT_W'(W - 1);
          pret_nxt = S_NRC;
          state_nxt = S_PSQ;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_NRC: begin
        if (pacc_r == p_r - one) begin
          pbase_nxt = W'(cand_r);
          pexp_nxt = q_r;
          pacc_nxt = one;
          pbit_nxt = msqrt_pkg::CNT_W'(W - 1);
          pret_nxt = S_CD;
          state_nxt = S_PSQ;
        end else begin
          cand_nxt = cand_r + 1'b1;
          state_nxt = S_NR;
        end
      end
      S_CD: begin
        c_nxt = pacc_r;
        pbase_nxt = a_r;
        pexp_nxt = (q_r >> 1) + one;
        pacc_nxt = one;
        pbit_nxt = msqrt_pkg::CNT_W'(W - 1);
        pret_nxt = S_XD;
        state_nxt = S_PSQ;
      end
      S_XD: begin
        x_nxt = pacc_r;
        pbase_nxt = a_r;
        pexp_nxt = q_r;
        pacc_nxt = one;
        pbit_nxt = msqrt_pkg::CNT_W'(W - 1);
        pret_nxt = S_TD;
        state_nxt = S_PSQ;
      end
      S_TD: begin
        t_nxt = pacc_r;
        m_nxt = s_r;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (t_r == one) begin
          froot_nxt = x_r;
          fhas_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          tt_nxt = t_r;
          i_nxt = '0;
          state_nxt = S_SQL;
        end
      end
      S_SQL: begin
        if (tt_r != one && i_r < m_r) begin
          mx_nxt = tt_r;
          my_nxt = tt_r;
          go_nxt = 1'b1;
          mret_nxt = S_SQD;
          state_nxt = S_MULW;
        end else if (tt_r != one || i_r >= m_r) begin
          state_nxt = S_FIN;
        end else begin
          b_nxt = c_r;
          j_nxt = '0;
          state_nxt = S_BL;
        end
      end
      S_SQD: begin
        tt_nxt = mres;
        i_nxt = i_r + 1'b1;
        state_nxt = S_SQL;
      end
      S_BL: begin
        mx_nxt = b_r;
        my_nxt = b_r;
        go_nxt = 1'b1;
        state_nxt = S_MULW;
        if (j_r + i_r + 1'b1 < m_r) begin
          mret_nxt = S_BD;
        end else begin
          mret_nxt = S_B2;
        end
      end
      S_BD: begin
        b_nxt = mres;
        j_nxt = j_r + 1'b1;
        state_nxt = S_BL;
      end
      S_B2: begin
        c_nxt = mres;
        mx_nxt = x_r;
        my_nxt = b_r;
        go_nxt = 1'b1;
        mret_nxt = S_XU;
        state_nxt = S_MULW;
      end
      S_XU: begin
        x_nxt = mres;
        mx_nxt = t_r;
        my_nxt = c_r;
        go_nxt = 1'b1;
        mret_nxt = S_TU;
        state_nxt = S_MULW;
      end
      S_TU: begin
        t_nxt = mres;
        m_nxt = i_r;
        state_nxt = S_LOOP;
      end
      S_FIN: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          oroot_nxt = 64'(froot_r);
          ohas_nxt = fhas_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r <= 1'b0;
      ov_r <= 1'b0;
      mod_r <= 64'd3;
    end else begin
      state_r <= state_nxt;
      go_r <= go_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) begin
        mod_r <= cfg_wdata;
      end
    end
    mret_r <= mret_nxt;
    pret_r <= pret_nxt;
    mx_r <= mx_nxt;
    my_r <= my_nxt;
    p_r <= p_nxt;
    a_r <= a_nxt;
    half_r <= half_nxt;
    q_r <= q_nxt;
    c_r <= c_nxt;
    x_r <= x_nxt;
    t_r <= t_nxt;
    tt_r <= tt_nxt;
    b_r <= b_nxt;
    pacc_r <= pacc_nxt;
    pbase_r <= pbase_nxt;
    pexp_r <= pexp_nxt;
    pbit_r <= pbit_nxt;
    s_r <= s_nxt;
    m_r <= m_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    cand_r <= cand_nxt;
    froot_r <= froot_nxt;
    fhas_r <= fhas_nxt;
    oroot_r <= oroot_nxt;
    ohas_r <= ohas_nxt;
  end

  assign out_valid = ov_r;
  assign out_root = oroot_r;
  assign out_has_root = ohas_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> !mul_busy)
    else $error("Multiplier started while busy.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("Input not stalled after a transfer.");

  a_no_root_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_root) |-> (out_root == 64'd0))
    else $error("Non-zero root reported without a root.");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MULW))
    else $error("Multiplier result arrived outside the wait state.");

endmodule

// ===== rtl/core/msqrt_mulmod.sv =====
// Bit-serial modular multiplier: x * y mod p, most significant bit of y first,
// one modular addition a cycle: a doubling, then a conditional add of x. Depends on msqrt_pkg.
module msqrt_mulmod (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  msqrt_pkg::data_t x,
  input  msqrt_pkg::data_t y,
  input  msqrt_pkg::data_t p,
  output logic             busy,
  output logic             done,
  output msqrt_pkg::data_t res
);

  logic                          busy_r, busy_nxt;
  logic                          phase_r, phase_nxt;
  logic                          done_r, done_nxt;
  logic [msqrt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  msqrt_pkg::data_t              acc_r, acc_nxt;
  msqrt_pkg::data_t              x_r, x_nxt;
  msqrt_pkg::data_t              y_r, y_nxt;
  msqrt_pkg::data_t              p_r, p_nxt;
  msqrt_pkg::data_t              opnd;
  msqrt_pkg::data_t              sum;

  assign opnd = phase_r ? x_r : acc_r;
  assign sum = msqrt_pkg::add_mod(acc_r, opnd, p_r);

  always_comb begin
    busy_nxt = busy_r;
    phase_nxt = phase_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    x_nxt = x_r;
    y_nxt = y_r;
    p_nxt = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      phase_nxt = 1'b0;
      cnt_nxt = msqrt_pkg::CNT_W'(msqrt_pkg::WIDTH - 1);
      acc_nxt = '0;
      x_nxt = x;
      y_nxt = y;
      p_nxt = p;
    end else if (busy_r) begin
      if (!phase_r) begin
        acc_nxt = sum;
        phase_nxt = 1'b1;
      end else begin
        if (y_r[msqrt_pkg::WIDTH-1]) begin
          acc_nxt = sum;
        end
        y_nxt = y_r << 1;
        phase_nxt = 1'b0;
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      phase_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      phase_r <= phase_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    p_r <= p_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res = acc_r;

endmodule

// ===== dv/modular_square_root_checker.sv =====
`timescale 1ns / 1ps
// Checker for the modular square root block: watches the configuration port and
// both channels, predicts each root and compares it. Depends on msqrt_pkg.
module modular_square_root_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  msqrt_pkg::data_t in_value,
  input  logic             out_valid,
  input  logic             out_stall,
  input  msqrt_pkg::data_t out_root,
  input  logic             out_has_root,
  input  logic             cfg_we,
  input  msqrt_pkg::data_t cfg_wdata,
  output int               fail_count,
  output int               pending,
  output int               roots_found,
  output int               roots_missing
);

  typedef struct packed {
    msqrt_pkg::data_t root;
    logic             has_root;
  } sqrt_result_t;

  localparam int SEARCH_LIMIT = 4096;
  localparam int DW = msqrt_pkg::WIDTH;

  msqrt_pkg::data_t prime;
  sqrt_result_t     expected_roots[$];

  function automatic msqrt_pkg::data_t mul_mod(msqrt_pkg::data_t x, msqrt_pkg::data_t y,
                                               msqrt_pkg::data_t m);
    logic [2*DW-1:0] prod;
    prod = (2*DW)'(x % m) * (2*DW)'(y % m);
    return msqrt_pkg::data_t'(prod % (2*DW)'(m));
  endfunction

  function automatic msqrt_pkg::data_t pow_mod(msqrt_pkg::data_t b, msqrt_pkg::data_t e,
                                               msqrt_pkg::data_t m);
    msqrt_pkg::data_t acc;
    acc = msqrt_pkg::data_t'(1) % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic sqrt_result_t square_root(msqrt_pkg::data_t value, msqrt_pkg::data_t p);
    sqrt_result_t r;
    msqrt_pkg::data_t a, half, q, z, c, x, t, tt, b, b2;
    int s, m, i;
    bit found;
    r = '0;
    if (p < 3 || !p[0]) return r;
    a = value % p;
    if (a == 0) begin
      r.has_root = 1'b1;
      return r;
    end
    half = (p - 1) / 2;
    if (pow_mod(a, half, p) != 1) return r;
    if (p[1:0] == 2'd3) begin
      r.root = pow_mod(a, p / 4 + 1, p);
      r.has_root = 1'b1;
      return r;
    end
    q = p - 1;
    s = 0;
    while (!q[0]) begin
      q = q >> 1;
      s++;
    end
    found = 0;
    z = 0;
    for (msqrt_pkg::data_t cand = 2; cand < p && cand < 2 + SEARCH_LIMIT; cand++) begin
      if (pow_mod(cand, half, p) == p - 1) begin
        z = cand;
        found = 1;
        break;
      end
    end
    if (!found) return r;
    c = pow_mod(z, q, p);
    x = pow_mod(a, (q + 1) / 2, p);
    t = pow_mod(a, q, p);
    m = s;
    while (t != 1) begin
      tt = t;
      i = 0;
      while (tt != 1 && i < m) begin
        tt = mul_mod(tt, tt, p);
        i++;
      end
      if (tt != 1 || i >= m) return r;
      b = c;
      for (int j = 0; j + i + 1 < m; j++) b = mul_mod(b, b, p);
      b2 = mul_mod(b, b, p);
      x = mul_mod(x, b, p);
      t = mul_mod(t, b2, p);
      c = b2;
      m = i;
    end
    r.root = x;
    r.has_root = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    sqrt_result_t want;
    if (!rst_n) begin
      prime = 64'd3;
      expected_roots.delete();
      fail_count <= 0;
      roots_found <= 0;
      roots_missing <= 0;
    end else begin
      if (cfg_we) prime = cfg_wdata;
      if (in_valid && !in_stall) expected_roots.push_back(square_root(in_value, prime));
      if (out_valid && !out_stall) begin
        if (expected_roots.size() == 0) begin
          $display("%0t: unexpected transfer, root %h has_root %b",
                   $time, out_root, out_has_root);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_roots.pop_front();
          if (want.root != out_root || want.has_root != out_has_root) begin
            $display("%0t: mismatch, expected root %h has_root %b, got root %h has_root %b",
                     $time, want.root, want.has_root, out_root, out_has_root);
            fail_count <= fail_count + 1;
          end
          if (want.has_root) roots_found <= roots_found + 1;
          else roots_missing <= roots_missing + 1;
        end
      end
    end
    pending <= expected_roots.size();
  end

endmodule

// ===== dv/modular_square_root_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the modular square root block: clock, reset, stimulus over
// several prime moduli and the verdict. Depends on msqrt_pkg and the checker.
module modular_square_root_top_test;

  localparam int NUM_PHASES = 9;
  localparam int RANDOM_PER_PHASE = 9;
  localparam longint CYCLE_LIMIT = 80000000;
  localparam int HOLD_CYCLES = 150000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  msqrt_pkg::data_t in_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  msqrt_pkg::data_t out_root;
  logic             out_has_root;
  logic             cfg_we = 1'b0;
  msqrt_pkg::data_t cfg_wdata = '0;

  int fail_count, pending, roots_found, roots_missing;
  logic in_taken = 1'b0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 0;
  longint cycles = 0;
  int items_sent = 0;

  msqrt_pkg::data_t primes[NUM_PHASES] = '{
    64'd3, 64'd7, 64'd13, 64'd17, 64'h1FFFFFFFFFFFFFFF, 64'd998244353,
    64'hFFFFFFFF00000001, 64'hFFFFFFFFFFFFFFC5, 64'd3};

  modular_square_root_top dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_value, .out_valid, .out_stall,
    .out_root, .out_has_root, .cfg_we, .cfg_wdata);

  modular_square_root_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_value, .out_valid, .out_stall,
    .out_root, .out_has_root, .cfg_we, .cfg_wdata, .fail_count, .pending,
    .roots_found, .roots_missing);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("modular_square_root_top test failed");
      $finish;
    end
  end

  // The receiver stalls at random, or for one long stretch on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_value(msqrt_pkg::data_t value);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(negedge clk); while (!in_taken);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic msqrt_pkg::data_t random_value(msqrt_pkg::data_t p);
    msqrt_pkg::data_t x;
    logic [127:0] sq;
    x = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        sq = 128'(x % p) * 128'(x % p);
        return msqrt_pkg::data_t'(sq % 128'(p));
      end
      6: return msqrt_pkg::data_t'($urandom_range(0, 40));
      default: return x;
    endcase
  endfunction

  initial begin
    msqrt_pkg::data_t p;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      p = primes[ph];
      if (ph > 0) begin
        cfg_we <= 1'b1;
        cfg_wdata <= p;
        @(negedge clk);
        cfg_we <= 1'b0;
      end
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 48; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 48; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      if (ph == 1) hold_request = 1;
      if (ph == 0) begin
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd2);
        send_value(64'd3);
      end else begin
        send_value(p - 1);
        send_value(64'hFFFFFFFFFFFFFFFF);
      end
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (ph == 2 && k == 4) drain();
        send_value(random_value(p));
      end
      drain();
    end
    repeat (200) @(negedge clk);
    $display("Covered %0d transfers over %0d prime moduli: %0d roots found, %0d non-residues.",
             items_sent, NUM_PHASES, roots_found, roots_missing);
    if (fail_count == 0) begin
      $display("modular_square_root_top test passed");
    end else begin
      $display("modular_square_root_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/msqrt_pkg.sv
rtl/core/msqrt_mulmod.sv
rtl/core/modular_square_root_top.sv
dv/modular_square_root_checker.sv
dv/modular_square_root_top_test.sv
